/* rtl/core/slr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slr_pkg
// Shared types and constants of the slope line rasteriser.
// ----------------------------------------------------------------------------
package slr_pkg;

   localparam int SCREEN_WIDTH = 320;

   localparam int X_W    = 9;
   localparam int Y_W    = 8;
   localparam int ADDR_W = 16;
   localparam int COL_W  = 8;

   localparam logic [ADDR_W-1:0] SCREEN_WIDTH_C = ADDR_W'(SCREEN_WIDTH);

   // divider: one quotient bit per cycle over the magnitude of dy
   localparam int DIV_STEPS = Y_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic MODE_START   = 1'b0;
   localparam logic MODE_ADVANCE = 1'b1;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_BODY  = 2'd1,
      PH_START = 2'd2,
      PH_END   = 2'd3
   } slr_phase_type;

   typedef enum logic [1:0] {
      KIND_VERT  = 2'd0,
      KIND_HORZ  = 2'd1,
      KIND_SLOPE = 2'd2
   } slr_kind_type;

   typedef enum logic [1:0] {
      CTL_ACCEPT = 2'd0,
      CTL_DIVIDE = 2'd1,
      CTL_FIXUP  = 2'd2
   } slr_ctl_state_type;

   typedef struct packed {
      logic load;
      logic advance;
      logic div_step;
      logic div_finish;
   } slr_cmd_type;

   typedef struct packed {
      logic out_valid;
   } slr_status_type;

endpackage

/* rtl/core/slr_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slr_req_if
// Request channel: line start and advance transactions.
// ----------------------------------------------------------------------------
interface slr_req_if;
   logic                     valid;
   logic                     ready;
   logic                     mode;
   logic [slr_pkg::X_W-1:0]  first_x;
   logic [slr_pkg::Y_W-1:0]  first_y;
   logic [slr_pkg::X_W-1:0]  second_x;
   logic [slr_pkg::Y_W-1:0]  second_y;
   logic [slr_pkg::COL_W-1:0] line_color;

   modport source (output valid, mode, first_x, first_y, second_x, second_y, line_color,
                   input ready);
   modport sink   (input valid, mode, first_x, first_y, second_x, second_y, line_color,
                   output ready);
endinterface

/* rtl/core/slr_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slr_rsp_if
// Response channel: one framebuffer write per transaction.
// ----------------------------------------------------------------------------
interface slr_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [slr_pkg::ADDR_W-1:0] pixel_address;
   logic [slr_pkg::COL_W-1:0]  pixel_color;
   logic                       last_pixel;

   modport source (output valid, pixel_address, pixel_color, last_pixel, input ready);
   modport sink   (input valid, pixel_address, pixel_color, last_pixel, output ready);
endinterface

/* rtl/core/slr_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slr_controller
// Handshake control and sequencing of the slope divider after a line start.
// ----------------------------------------------------------------------------
module slr_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_mode,
   input  logic                    rsp_ready,
   input  slr_pkg::slr_status_type status,
   output logic                    req_ready,
   output slr_pkg::slr_cmd_type    cmd
);

   slr_pkg::slr_ctl_state_type    state_ff, state_in;
   logic [slr_pkg::DIV_CNT_W-1:0] count_ff, count_in;
   logic                          accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= slr_pkg::CTL_ACCEPT;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      req_ready      = 1'b0;
      accept         = 1'b0;
      cmd.load       = 1'b0;
      cmd.advance    = 1'b0;
      cmd.div_step   = 1'b0;
      cmd.div_finish = 1'b0;
      case (state_ff)
         slr_pkg::CTL_ACCEPT: begin
            // take a transaction only when the output register can hold its result
            req_ready   = !status.out_valid || rsp_ready;
            accept      = req_valid && req_ready;
            cmd.load    = accept && (req_mode == slr_pkg::MODE_START);
            cmd.advance = accept && (req_mode == slr_pkg::MODE_ADVANCE);
            if (cmd.load) begin
               state_in = slr_pkg::CTL_DIVIDE;
               count_in = '0;
            end
         end
         slr_pkg::CTL_DIVIDE: begin
            cmd.div_step = 1'b1;
            count_in     = count_ff + 1'b1;
            if (count_ff == slr_pkg::DIV_CNT_W'(slr_pkg::DIV_STEPS - 1)) begin
               state_in = slr_pkg::CTL_FIXUP;
            end
         end
         slr_pkg::CTL_FIXUP: begin
            cmd.div_finish = 1'b1;
            state_in       = slr_pkg::CTL_ACCEPT;
         end
         default: begin
            state_in = slr_pkg::CTL_ACCEPT;
         end
      endcase
   end

   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != slr_pkg::CTL_ACCEPT) |-> !req_ready)
      else $error("request accepted while the divider runs");

   a_load_divides: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == slr_pkg::CTL_DIVIDE) && (count_ff == '0))
      else $error("line start did not launch the divider");

   a_divide_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == slr_pkg::CTL_DIVIDE) && (count_ff == slr_pkg::DIV_CNT_W'(slr_pkg::DIV_STEPS - 1))
      |=> (state_ff == slr_pkg::CTL_FIXUP))
      else $error("divider did not finish after its last step");

   a_single_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.advance, cmd.div_step, cmd.div_finish}))
      else $error("conflicting datapath commands");

endmodule

/* rtl/core/slr_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slr_datapath
// Endpoint registers, slope divider, incremental y stepping and output register.
// ----------------------------------------------------------------------------
module slr_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  slr_pkg::slr_cmd_type         cmd,
   input  logic [slr_pkg::X_W-1:0]      req_first_x,
   input  logic [slr_pkg::Y_W-1:0]      req_first_y,
   input  logic [slr_pkg::X_W-1:0]      req_second_x,
   input  logic [slr_pkg::Y_W-1:0]      req_second_y,
   input  logic [slr_pkg::COL_W-1:0]    req_line_color,
   input  logic                         rsp_ready,
   output slr_pkg::slr_status_type      status,
   output logic                         rsp_valid,
   output logic [slr_pkg::ADDR_W-1:0]   rsp_pixel_address,
   output logic [slr_pkg::COL_W-1:0]    rsp_pixel_color,
   output logic                         rsp_last_pixel
);

   localparam int XW = slr_pkg::X_W;
   localparam int YW = slr_pkg::Y_W;
   localparam int AW = slr_pkg::ADDR_W;
   localparam int CW = slr_pkg::COL_W;

   // control state
   slr_pkg::slr_phase_type phase_ff, phase_in;
   slr_pkg::slr_kind_type  kind_ff, kind_in;
   logic [XW-1:0]          pos_ff, pos_in;
   logic [XW-1:0]          limit_ff, limit_in;
   logic [XW-1:0]          x0_ff, x0_in, x1_ff, x1_in;
   logic [YW-1:0]          y0_ff, y0_in, y1_ff, y1_in;
   logic [CW-1:0]          color_ff, color_in;
   logic                   out_valid_ff, out_valid_in;

   // payload
   logic [XW-1:0]          dvsr_ff, dvsr_in;
   logic                   neg_ff, neg_in;
   logic [XW-1:0]          div_rem_ff, div_rem_in;
   logic [YW-1:0]          div_quo_ff, div_quo_in;
   logic [YW-1:0]          step_q_ff, step_q_in;
   logic [XW-1:0]          step_r_ff, step_r_in;
   logic [YW-1:0]          ycur_ff, ycur_in;
   logic [XW-1:0]          frac_ff, frac_in;
   logic [AW-1:0]          addr_ff, addr_in;
   logic [CW-1:0]          out_color_ff, out_color_in;
   logic                   last_ff, last_in;

   // combinational helpers
   logic                   ascend;
   logic                   dy_neg;
   logic [YW-1:0]          dy_mag;
   logic [XW-1:0]          span_a, span_b;
   logic [XW:0]            trial;
   logic                   trial_ge;
   logic [XW:0]            frac_sum;
   logic                   frac_wrap;
   logic                   in_body;
   logic [XW-1:0]          pix_x;
   logic [YW-1:0]          pix_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= slr_pkg::PH_IDLE;
         kind_ff      <= slr_pkg::KIND_VERT;
         pos_ff       <= '0;
         limit_ff     <= '0;
         x0_ff        <= '0;
         y0_ff        <= '0;
         x1_ff        <= '0;
         y1_ff        <= '0;
         color_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         kind_ff      <= kind_in;
         pos_ff       <= pos_in;
         limit_ff     <= limit_in;
         x0_ff        <= x0_in;
         y0_ff        <= y0_in;
         x1_ff        <= x1_in;
         y1_ff        <= y1_in;
         color_ff     <= color_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dvsr_ff      <= dvsr_in;
      neg_ff       <= neg_in;
      div_rem_ff   <= div_rem_in;
      div_quo_ff   <= div_quo_in;
      step_q_ff    <= step_q_in;
      step_r_ff    <= step_r_in;
      ycur_ff      <= ycur_in;
      frac_ff      <= frac_in;
      addr_ff      <= addr_in;
      out_color_ff <= out_color_in;
      last_ff      <= last_in;
   end

   always_comb begin
      ascend   = req_first_x < req_second_x;
      dy_neg   = req_second_y < req_first_y;
      dy_mag   = dy_neg ? (req_first_y - req_second_y) : (req_second_y - req_first_y);
      if (req_first_x == req_second_x) begin
         span_a = XW'(req_first_y);
         span_b = XW'(req_second_y);
      end else begin
         span_a = req_first_x;
         span_b = req_second_x;
      end

      trial    = {div_rem_ff, div_quo_ff[YW-1]};
      trial_ge = trial >= {1'b0, dvsr_ff};

      frac_sum  = {1'b0, frac_ff} + {1'b0, step_r_ff};
      frac_wrap = frac_sum >= {1'b0, dvsr_ff};

      in_body = (phase_ff == slr_pkg::PH_BODY) && (pos_ff < limit_ff);
      case (kind_ff)
         slr_pkg::KIND_VERT: begin
            pix_x = x0_ff;
            pix_y = pos_ff[YW-1:0];
         end
         slr_pkg::KIND_HORZ: begin
            pix_x = pos_ff;
            pix_y = y0_ff;
         end
         default: begin
            pix_x = pos_ff;
            pix_y = ycur_ff;
         end
      endcase
   end

   always_comb begin
      phase_in     = phase_ff;
      kind_in      = kind_ff;
      pos_in       = pos_ff;
      limit_in     = limit_ff;
      x0_in        = x0_ff;
      y0_in        = y0_ff;
      x1_in        = x1_ff;
      y1_in        = y1_ff;
      color_in     = color_ff;
      dvsr_in      = dvsr_ff;
      neg_in       = neg_ff;
      div_rem_in   = div_rem_ff;
      div_quo_in   = div_quo_ff;
      step_q_in    = step_q_ff;
      step_r_in    = step_r_ff;
      ycur_in      = ycur_ff;
      frac_in      = frac_ff;
      addr_in      = addr_ff;
      out_color_in = out_color_ff;
      last_in      = last_ff;
      out_valid_in = out_valid_ff && !rsp_ready;

      if (cmd.load) begin
         x0_in      = req_first_x;
         y0_in      = req_first_y;
         x1_in      = req_second_x;
         y1_in      = req_second_y;
         color_in   = req_line_color;
         if (req_first_x == req_second_x) begin
            kind_in = slr_pkg::KIND_VERT;
         end else if (req_first_y == req_second_y) begin
            kind_in = slr_pkg::KIND_HORZ;
         end else begin
            kind_in = slr_pkg::KIND_SLOPE;
         end
         pos_in     = (span_a < span_b) ? span_a : span_b;
         limit_in   = (span_a < span_b) ? span_b : span_a;
         phase_in   = slr_pkg::PH_BODY;
         dvsr_in    = ascend ? (req_second_x - req_first_x) : (req_first_x - req_second_x);
         neg_in     = dy_neg ^ !ascend;
         div_rem_in = '0;
         div_quo_in = dy_mag;
         ycur_in    = ascend ? req_first_y : req_second_y;
         frac_in    = '0;
      end

      if (cmd.div_step) begin
         div_rem_in = trial_ge ? XW'(trial - {1'b0, dvsr_ff}) : trial[XW-1:0];
         div_quo_in = {div_quo_ff[YW-2:0], trial_ge};
      end

      if (cmd.div_finish) begin
         // floor division of the signed per-column step
         if (!neg_ff) begin
            step_q_in = div_quo_ff;
            step_r_in = div_rem_ff;
         end else if (div_rem_ff != '0) begin
            step_q_in = ~div_quo_ff;
            step_r_in = dvsr_ff - div_rem_ff;
         end else begin
            step_q_in = YW'(0) - div_quo_ff;
            step_r_in = '0;
         end
      end

      if (cmd.advance && (phase_ff != slr_pkg::PH_IDLE)) begin
         out_valid_in = 1'b1;
         out_color_in = color_ff;
         last_in      = 1'b0;
         if (in_body) begin
            addr_in = AW'(slr_pkg::SCREEN_WIDTH_C * AW'(pix_y)) + AW'(pix_x);
            pos_in  = pos_ff + 1'b1;
            frac_in = frac_wrap ? XW'(frac_sum - {1'b0, dvsr_ff}) : frac_sum[XW-1:0];
            ycur_in = ycur_ff + step_q_ff + YW'(frac_wrap);
         end else if (phase_ff != slr_pkg::PH_END) begin
            addr_in  = AW'(slr_pkg::SCREEN_WIDTH_C * AW'(y0_ff)) + AW'(x0_ff);
            phase_in = slr_pkg::PH_END;
         end else begin
            addr_in  = AW'(slr_pkg::SCREEN_WIDTH_C * AW'(y1_ff)) + AW'(x1_ff);
            last_in  = 1'b1;
            phase_in = slr_pkg::PH_IDLE;
         end
      end
   end

   assign status.out_valid  = out_valid_ff;
   assign rsp_valid         = out_valid_ff;
   assign rsp_pixel_address = addr_ff;
   assign rsp_pixel_color   = out_color_ff;
   assign rsp_last_pixel    = last_ff;

   a_end_closes: assert property (@(posedge clock) disable iff (reset)
      cmd.advance && (phase_ff == slr_pkg::PH_END)
      |=> out_valid_ff && last_ff && (phase_ff == slr_pkg::PH_IDLE))
      else $error("end pixel did not close the line");

   a_frac_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == slr_pkg::PH_BODY) && (kind_ff == slr_pkg::KIND_SLOPE)
      |-> (frac_ff < dvsr_ff))
      else $error("slope remainder out of range");

   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      cmd.advance && (phase_ff == slr_pkg::PH_IDLE) && !out_valid_ff |=> !out_valid_ff)
      else $error("write produced with no active line");

   a_body_span: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == slr_pkg::PH_BODY) |-> (pos_ff <= limit_ff))
      else $error("body position ran past its limit");

endmodule

/* rtl/core/slope_line_rasterizer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slope_line_rasterizer
// Line engine for a byte-per-pixel framebuffer, one write per advance on an active line.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries start transactions (mode 0: endpoints and colour) and
//   advance transactions (mode 1). rsp_chan carries framebuffer writes:
//   address = SCREEN_WIDTH * y + x (modulo 2^16), colour and a last flag.
//   A start produces no write; the block then runs 8 divider steps for the
//   slope and 1 fix-up with req_chan.ready low. While a line is active, an
//   accepted advance puts its write in the output register on the next
//   cycle, so advances sustain one pixel per cycle while rsp_chan takes
//   every write. Body pixels come first, then the start point, then the
//   end point flagged last_pixel.
//   An advance with no active line is accepted and dropped.
//   Reset (synchronous) clears the line state and the output valid flag.
//   When rsp_chan stalls, the pending write holds and req_chan.ready drops
//   until it is taken; a new transaction enters in the cycle it leaves.
// ----------------------------------------------------------------------------
module slope_line_rasterizer (
   input  logic       clock,
   input  logic       reset,
   slr_req_if.sink    req_chan,
   slr_rsp_if.source  rsp_chan
);

   slr_pkg::slr_cmd_type    cmd;
   slr_pkg::slr_status_type status;

   slr_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_mode  (req_chan.mode),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .req_ready (req_chan.ready),
      .cmd       (cmd)
   );

   slr_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_first_x       (req_chan.first_x),
      .req_first_y       (req_chan.first_y),
      .req_second_x      (req_chan.second_x),
      .req_second_y      (req_chan.second_y),
      .req_line_color    (req_chan.line_color),
      .rsp_ready         (rsp_chan.ready),
      .status            (status),
      .rsp_valid         (rsp_chan.valid),
      .rsp_pixel_address (rsp_chan.pixel_address),
      .rsp_pixel_color   (rsp_chan.pixel_color),
      .rsp_last_pixel    (rsp_chan.last_pixel)
   );

endmodule

/* dv/slr_pixel_predictor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slr_pixel_predictor
// Watches both channels of the line rasteriser. Every accepted request
// transaction is run through a local model of the line engine, and the
// framebuffer write it should cause, if any, is queued. Every accepted response
// transaction is compared field by field with the oldest queued write.
// The failure count and the number of outstanding writes go to the top.
// ----------------------------------------------------------------------------
module slr_pixel_predictor
   import slr_pkg::*;
(
   input  logic clock,
   input  logic reset,
   slr_req_if   req_chan,
   slr_rsp_if   rsp_chan,
   output int   fail_count,
   output int   pending_count
);

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [COL_W-1:0]  color;
      logic              last;
   } pixel_write_type;

   pixel_write_type expected_writes[$];

   slr_phase_type    line_phase;
   slr_kind_type     line_kind;
   logic [X_W-1:0]   step_position;
   logic [X_W-1:0]   step_limit;
   logic [X_W-1:0]   held_first_x;
   logic [Y_W-1:0]   held_first_y;
   logic [X_W-1:0]   held_second_x;
   logic [Y_W-1:0]   held_second_y;
   logic [COL_W-1:0] held_color;
   int               failures = 0;

   function automatic logic [ADDR_W-1:0] pixel_offset(input logic [X_W-1:0] x,
                                                      input logic [Y_W-1:0] y);
      return ADDR_W'(SCREEN_WIDTH * int'(y) + int'(x));
   endfunction

   always @(posedge clock) begin : monitor
      pixel_write_type got;
      pixel_write_type want;
      logic [X_W-1:0]  px;
      logic [Y_W-1:0]  py;
      logic [X_W-1:0]  lo_end;
      logic [X_W-1:0]  hi_end;
      longint          run;
      longint          rise;
      longint          num;
      longint          quo;
      if (reset) begin
         expected_writes.delete();
         line_phase    = PH_IDLE;
         line_kind     = KIND_VERT;
         step_position = '0;
         step_limit    = '0;
         held_first_x  = '0;
         held_first_y  = '0;
         held_second_x = '0;
         held_second_y = '0;
         held_color    = '0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.addr  = rsp_chan.pixel_address;
            got.color = rsp_chan.pixel_color;
            got.last  = rsp_chan.last_pixel;
            if (expected_writes.size() == 0) begin
               if (failures < 10)
                  $display("%0t: unexpected write addr=%h color=%h last=%b",
                           $realtime, got.addr, got.color, got.last);
               failures++;
            end else begin
               want = expected_writes.pop_front();
               if (got.addr != want.addr || got.color != want.color ||
                   got.last != want.last) begin
                  if (failures < 10)
                     $display("%0t: write mismatch exp addr=%h color=%h last=%b, got addr=%h color=%h last=%b",
                              $realtime, want.addr, want.color, want.last,
                              got.addr, got.color, got.last);
                  failures++;
               end
            end
         end

         if (req_chan.valid && req_chan.ready) begin
            if (req_chan.mode == MODE_START) begin
               held_first_x  = req_chan.first_x;
               held_first_y  = req_chan.first_y;
               held_second_x = req_chan.second_x;
               held_second_y = req_chan.second_y;
               held_color    = req_chan.line_color;
               if (held_first_x == held_second_x) begin
                  line_kind = KIND_VERT;
                  lo_end    = {1'b0, held_first_y};
                  hi_end    = {1'b0, held_second_y};
               end else begin
                  if (held_first_y == held_second_y)
                     line_kind = KIND_HORZ;
                  else
                     line_kind = KIND_SLOPE;
                  lo_end = held_first_x;
                  hi_end = held_second_x;
               end
               step_position = (lo_end < hi_end) ? lo_end : hi_end;
               step_limit    = (lo_end < hi_end) ? hi_end : lo_end;
               line_phase    = PH_BODY;
            end else if (line_phase != PH_IDLE) begin
               if (line_phase == PH_BODY && step_position >= step_limit)
                  line_phase = PH_START;
               want.color = held_color;
               want.last  = 1'b0;
               case (line_phase)
                  PH_BODY: begin
                     px = (line_kind == KIND_VERT) ? held_first_x : step_position;
                     py = held_first_y;
                     if (line_kind == KIND_VERT) begin
                        py = step_position[Y_W-1:0];
                     end else if (line_kind == KIND_SLOPE) begin
                        run  = longint'(held_second_x) - longint'(held_first_x);
                        rise = longint'(held_second_y) - longint'(held_first_y);
                        num  = rise * (longint'(step_position) - longint'(held_first_x));
                        if (run < 0) begin
                           run = -run;
                           num = -num;
                        end
                        // floor division, rounding towards minus infinity
                        if (num >= 0)
                           quo = num / run;
                        else
                           quo = -((-num + run - 1) / run);
                        py = Y_W'(longint'(held_first_y) + quo);
                     end
                     step_position = step_position + 1'b1;
                     want.addr = pixel_offset(px, py);
                  end
                  PH_START: begin
                     want.addr  = pixel_offset(held_first_x, held_first_y);
                     line_phase = PH_END;
                  end
                  default: begin
                     want.addr  = pixel_offset(held_second_x, held_second_y);
                     want.last  = 1'b1;
                     line_phase = PH_IDLE;
                  end
               endcase
               expected_writes.push_back(want);
            end
         end
      end
      pending_count <= expected_writes.size();
      fail_count    <= failures;
   end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the slope line rasteriser. A directed set of
// lines covers the corner cases, then random lines, mostly short and well
// formed with some aborted or over-advanced, run under three idling
// profiles. Checking is done by slr_pixel_predictor alongside the block.
// ----------------------------------------------------------------------------
module testbench;
   import slr_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_ITEMS  = 133;

   logic clock;
   logic reset;
   int   source_idle_pct = 38;
   int   sink_stall_pct  = 62;
   int   items_sent      = 0;
   int   cycle_count     = 0;
   int   fail_count;
   int   pending_count;

   slr_req_if req_chan();
   slr_rsp_if rsp_chan();

   slope_line_rasterizer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   slr_pixel_predictor pixel_check (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= sink_stall_pct);
      cycle_count    <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic send_txn(input logic             mode,
                           input logic [X_W-1:0]   fx,
                           input logic [Y_W-1:0]   fy,
                           input logic [X_W-1:0]   sx,
                           input logic [Y_W-1:0]   sy,
                           input logic [COL_W-1:0] col);
      while ($urandom_range(99) < source_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.mode       <= mode;
      req_chan.first_x    <= fx;
      req_chan.first_y    <= fy;
      req_chan.second_x   <= sx;
      req_chan.second_y   <= sy;
      req_chan.line_color <= col;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
   endtask

   task automatic send_advance();
      send_txn(MODE_ADVANCE, X_W'($urandom), Y_W'($urandom), X_W'($urandom),
               Y_W'($urandom), COL_W'($urandom));
   endtask

   task automatic send_line(input int fx, input int fy, input int sx, input int sy,
                            input int col, input int advances);
      send_txn(MODE_START, X_W'(fx), Y_W'(fy), X_W'(sx), Y_W'(sy), COL_W'(col));
      repeat (advances) send_advance();
   endtask

   task automatic drain_writes();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   initial begin
      int ph;
      int base;
      int shape;
      int big;
      int lo;
      int hi;
      int n;
      int r;
      int room;
      int fx;
      int fy;
      int sx;
      int sy;
      req_chan.valid      <= 1'b0;
      req_chan.mode       <= MODE_START;
      req_chan.first_x    <= '0;
      req_chan.first_y    <= '0;
      req_chan.second_x   <= '0;
      req_chan.second_y   <= '0;
      req_chan.line_color <= '0;
      reset               <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_advance();
      send_line(5, 5, 5, 5, 255, 2);
      send_line(10, 7, 10, 4, 0, 5);
      send_line(300, 199, 298, 199, 'hA5, 4);
      send_line(0, 0, 2, 255, 'h5A, 1);
      send_line(511, 255, 509, 0, 'hFF, 4);
      send_line(3, 3, 4, 9, 1, 3);
      base = items_sent;

      for (ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               source_idle_pct = 38;
               sink_stall_pct  = 62;
            end
            1: begin
               source_idle_pct = 62;
               sink_stall_pct  = 38;
            end
            default: begin
               source_idle_pct = 0;
               sink_stall_pct  = 0;
            end
         endcase
         while (items_sent - base < (ph + 1) * PHASE_ITEMS) begin
            shape = $urandom_range(9);
            big   = ($urandom_range(29) == 0);
            if (big) begin
               fx = $urandom_range(511);
               fy = $urandom_range(255);
               sx = $urandom_range(511);
               sy = $urandom_range(255);
            end else begin
               fx = $urandom_range(319);
               fy = $urandom_range(199);
               lo = (fx > 12) ? fx - 12 : 0;
               hi = (fx < 499) ? fx + 12 : 511;
               sx = $urandom_range(hi, lo);
               lo = (fy > 12) ? fy - 12 : 0;
               hi = (fy < 243) ? fy + 12 : 255;
               sy = $urandom_range(hi, lo);
               if (shape >= 5 && $urandom_range(3) == 0)
                  sy = $urandom_range(255);
            end
            if (shape <= 1)
               sx = fx;
            else if (shape <= 3)
               sy = fy;
            else if (shape == 4) begin
               sx = fx;
               sy = fy;
            end
            if (fx == sx)
               n = ((fy > sy) ? fy - sy : sy - fy) + 2;
            else
               n = ((fx > sx) ? fx - sx : sx - fx) + 2;
            r = $urandom_range(9);
            // abort early on some lines, over-advance into idle on others
            if (r == 0)
               n = $urandom_range(n - 1);
            else if (r == 1)
               n = n + $urandom_range(3);
            // hold the phase to its share of transactions
            room = (ph + 1) * PHASE_ITEMS - (items_sent - base) - 1;
            if (n > room)
               n = (room > 0) ? room : 0;
            send_line(fx, fy, sx, sy, $urandom_range(255), n);
         end
         if (ph < 2)
            drain_writes();
      end

      drain_writes();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
